FILE: src/kinematic_bicycle_euler_step_assert.svh
// Assertion macros shared by the kinematic bicycle step RTL.
// Expects clk and arst_n in scope at the point of use.
`ifndef KINEMATIC_BICYCLE_EULER_STEP_ASSERT_SVH
`define KINEMATIC_BICYCLE_EULER_STEP_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define KBE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define KBE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/kbe_pkg.sv
// Shared constants and types for the kinematic bicycle step pipeline.
// No dependencies; imported by the CORDIC unit and the top level.
`timescale 1ns / 1ps

package kbe_pkg;

	localparam int ATAN_LEN = 24;
	localparam int ANG_W    = 34;

	typedef logic signed [ANG_W-1:0] ang_t;

	// Angles are in units of 2^-32 turn.
	localparam ang_t QUARTER_TURN = 34'sd1073741824;
	localparam ang_t HALF_TURN    = 34'sd2147483648;
	localparam ang_t CORDIC_GAIN  = 34'sd652032874;

	localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	localparam logic [16:0]        STEER_TO_TURN = 17'd83443;
	localparam logic [29:0]        RAD_TO_BAM    = 30'd683565276;
	localparam logic signed [14:0] STEER_LIMIT   = 15'sd10650;

	// Tangent magnitude in Q16 stays below 2^18 for the steering range.
	localparam int TQ_W = 20;

	localparam int             CFG_IDX_W      = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE = 2'd1;

endpackage

FILE: src/kbe_cordic.sv
// Pipelined CORDIC rotator, one micro-rotation per register stage.
// Depends on kbe_pkg for the arctangent table and gain.
`timescale 1ns / 1ps

module kbe_cordic import kbe_pkg::*; #(
	parameter int STAGES = 16,
	parameter int SB_W   = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  ang_t            ang_i,
	input  logic [SB_W-1:0] sb_i,
	output logic            vld_o,
	output ang_t            cos_o,
	output ang_t            sin_o,
	output logic [SB_W-1:0] sb_o
);

	logic            vld_s [STAGES];
	ang_t            x_s   [STAGES];
	ang_t            y_s   [STAGES];
	ang_t            z_s   [STAGES];
	logic [SB_W-1:0] sb_s  [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic            vp;
		ang_t            xp, yp, zp, xsh, ysh, rot;
		logic [SB_W-1:0] sbp;

		if (i == 0) begin : g_head
			assign vp  = vld_i;
			assign xp  = CORDIC_GAIN;
			assign yp  = '0;
			assign zp  = ang_i;
			assign sbp = sb_i;
		end else begin : g_body
			assign vp  = vld_s[i-1];
			assign xp  = x_s[i-1];
			assign yp  = y_s[i-1];
			assign zp  = z_s[i-1];
			assign sbp = sb_s[i-1];
		end

		assign xsh = xp >>> i;
		assign ysh = yp >>> i;
		assign rot = $signed({2'b00, ATAN_TURN[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vp;
			end
		end

		// rotate toward zero residual angle
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zp[ANG_W-1]) begin
					x_s[i] <= xp - ysh;
					y_s[i] <= yp + xsh;
					z_s[i] <= zp - rot;
				end else begin
					x_s[i] <= xp + ysh;
					y_s[i] <= yp - xsh;
					z_s[i] <= zp + rot;
				end
				sb_s[i] <= sbp;
			end
		end
	end

	assign vld_o = vld_s[STAGES-1];
	assign cos_o = x_s[STAGES-1];
	assign sin_o = y_s[STAGES-1];
	assign sb_o  = sb_s[STAGES-1];

endmodule

FILE: src/kbe_div.sv
// Pipelined restoring divider for unsigned operands, one quotient bit per stage.
// Standalone; the top level feeds it magnitudes and handles signs.
`timescale 1ns / 1ps

module kbe_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32,
	parameter int SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_i,
	input  logic [NUM_W-1:0] num_i,
	input  logic [DEN_W-1:0] den_i,
	input  logic [SB_W-1:0]  sb_i,
	output logic             vld_o,
	output logic [NUM_W-1:0] quo_o,
	output logic [SB_W-1:0]  sb_o
);

	logic             vld_s [NUM_W];
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];
	logic [SB_W-1:0]  sb_s  [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic             vp, ge;
		logic [DEN_W-1:0] remp, denp;
		logic [NUM_W-1:0] nqp;
		logic [SB_W-1:0]  sbp;
		logic [DEN_W:0]   trial, diff;

		if (i == 0) begin : g_head
			assign vp   = vld_i;
			assign remp = '0;
			assign nqp  = num_i;
			assign denp = den_i;
			assign sbp  = sb_i;
		end else begin : g_body
			assign vp   = vld_s[i-1];
			assign remp = rem_s[i-1];
			assign nqp  = nq_s[i-1];
			assign denp = den_s[i-1];
			assign sbp  = sb_s[i-1];
		end

		// shift in the next dividend bit, subtract when it fits
		assign trial = {remp, nqp[NUM_W-1]};
		assign ge    = trial >= {1'b0, denp};
		assign diff  = trial - {1'b0, denp};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				nq_s[i]  <= {nqp[NUM_W-2:0], ge};
				den_s[i] <= denp;
				sb_s[i]  <= sbp;
			end
		end
	end

	assign vld_o = vld_s[NUM_W-1];
	assign quo_o = nq_s[NUM_W-1];
	assign sb_o  = sb_s[NUM_W-1];

endmodule

FILE: src/kinematic_bicycle_euler_step.sv
// Top level of the kinematic bicycle forward-Euler step pipeline.
// Uses kbe_pkg, kbe_cordic, kbe_div and the assertion macro header.
`timescale 1ns / 1ps
`include "kinematic_bicycle_euler_step_assert.svh"

// Usage
//   Input channel: in_valid/in_ready with pos_x, pos_y, heading, speed, steer,
//   accel; one transfer is one vehicle state. Output channel: out_valid/out_ready
//   with next_pos_x, next_pos_y, next_heading, next_speed; one transfer per input.
//   Config channel: cfg_valid/cfg_ready, cfg_index 0 = time_step, 1 = wheel_base,
//   other indexes are dropped. cfg_ready is always high; write only while idle.
//   Pipeline order from input transfer to out_valid: s1, s2, the CORDIC stages,
//   s3, s4, the two bit-per-stage dividers (tangent, 48 stages; s5; yaw rate over
//   wheel base, 52 stages), then s6 and s7. Throughput: one item per cycle while
//   no stall holds the pipe.
//   Reset: all valid bits clear, time_step = 655, wheel_base = 691.
//   Stall: when out_valid is high and out_ready low, the whole pipe holds and
//   in_ready drops; bubbles inside the pipe hold too. Nothing is lost or repeated.
//   Results come out in input order.

module kinematic_bicycle_euler_step import kbe_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic [15:0]          heading,
	input  logic signed [31:0]   speed,
	input  logic signed [14:0]   steer,
	input  logic signed [15:0]   accel,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   next_pos_x,
	output logic signed [31:0]   next_pos_y,
	output logic [15:0]          next_heading,
	output logic signed [31:0]   next_speed,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam int D1_NUM_W = 48;
	localparam int D1_DEN_W = 32;
	localparam int D2_NUM_W = 32 + TQ_W;
	localparam int D2_DEN_W = 16;
	localparam int R_W      = 56;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [15:0]        hd;
		logic               hflip;
		logic signed [31:0] nspd;
	} hsb_t;

	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic [15:0]        hd;
		logic signed [31:0] nspd;
		logic [31:0]        dmag;
		logic               rneg;
	} d1sb_t;

	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic [15:0]        hd;
		logic signed [31:0] nspd;
		logic               rneg;
	} d2sb_t;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -35'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// ---------------------------------------------------------------- config
	logic [15:0] time_step_q, wheel_base_q, wb_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q  <= 16'd655;
			wheel_base_q <= 16'd691;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TIME_STEP:  time_step_q  <= cfg_data;
				REG_WHEEL_BASE: wheel_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a zero wheel base counts as the smallest step
	assign wb_eff = (wheel_base_q == '0) ? 16'd1 : wheel_base_q;

	// ---------------------------------------------------------------- flow
	// Global advance: the pipe moves unless the output holds an untaken result.
	logic adv, vld_s7;

	assign adv       = !vld_s7 || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s7;

	// ---------------------------------------------------------------- s1: capture
	logic                vld_s1;
	logic signed [31:0]  px_s1, py_s1, v_s1;
	logic [15:0]         hd_s1;
	logic signed [14:0]  st_s1, st_sat;
	logic signed [15:0]  ac_s1;

	always_comb begin
		if (steer > STEER_LIMIT) begin
			st_sat = STEER_LIMIT;
		end else if (steer < -STEER_LIMIT) begin
			st_sat = -STEER_LIMIT;
		end else begin
			st_sat = steer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= pos_x;
			py_s1 <= pos_y;
			hd_s1 <= heading;
			v_s1  <= speed;
			st_s1 <= st_sat;
			ac_s1 <= accel;
		end
	end

	// ---------------------------------------------------------------- s2: angles, travel
	ang_t               ha_raw, ha_fold, ha_s2, sang_s2;
	logic               hflip, hflip_s2, vld_s2;
	logic signed [32:0] sang_p;
	logic signed [48:0] vdt, vdt_r;
	logic signed [32:0] adt, adt_r;
	logic signed [31:0] d_s2, px_s2, py_s2, v_s2;
	logic signed [24:0] dv_s2;
	logic [15:0]        hd_s2;

	assign ha_raw = ANG_W'($signed({hd_s1, 16'h0000}));

	// fold the heading into a quarter turn of zero; s3 undoes it by negating the rotator outputs
	always_comb begin
		if (ha_raw > QUARTER_TURN) begin
			ha_fold = ha_raw - HALF_TURN;
			hflip   = 1'b1;
		end else if (ha_raw < -QUARTER_TURN) begin
			ha_fold = ha_raw + HALF_TURN;
			hflip   = 1'b1;
		end else begin
			ha_fold = ha_raw;
			hflip   = 1'b0;
		end
	end

	assign sang_p = st_s1 * $signed({1'b0, STEER_TO_TURN});
	assign vdt    = v_s1 * $signed({1'b0, time_step_q});
	assign vdt_r  = vdt + 49'sd32768;
	assign adt    = ac_s1 * $signed({1'b0, time_step_q});
	assign adt_r  = adt + 33'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ha_s2    <= ha_fold;
			hflip_s2 <= hflip;
			sang_s2  <= ANG_W'(sang_p);
			d_s2     <= vdt_r[47:16];
			dv_s2    <= adt_r[32:8];
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			hd_s2    <= hd_s1;
			v_s2     <= v_s1;
		end
	end

	// ---------------------------------------------------------------- CORDIC pair
	hsb_t               hsb_in, hsb_out;
	logic signed [31:0] d_c;
	logic               h_vld, s_vld;
	ang_t               hx, hy, sx, sy;

	assign hsb_in.px    = px_s2;
	assign hsb_in.py    = py_s2;
	assign hsb_in.hd    = hd_s2;
	assign hsb_in.hflip = hflip_s2;
	assign hsb_in.nspd  = sat32(35'(v_s2) + 35'(dv_s2));

	kbe_cordic #(
		.STAGES (CORDIC_STAGES),
		.SB_W   ($bits(hsb_t))
	) u_cordic_head (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (vld_s2),
		.ang_i  (ha_s2),
		.sb_i   (hsb_in),
		.vld_o  (h_vld),
		.cos_o  (hx),
		.sin_o  (hy),
		.sb_o   (hsb_out)
	);

	kbe_cordic #(
		.STAGES (CORDIC_STAGES),
		.SB_W   (32)
	) u_cordic_steer (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (vld_s2),
		.ang_i  (sang_s2),
		.sb_i   (d_s2),
		.vld_o  (s_vld),
		.cos_o  (sx),
		.sin_o  (sy),
		.sb_o   (d_c)
	);

	// ---------------------------------------------------------------- s3: unfold, clamp
	logic               vld_s3;
	ang_t               hc_s3, hs_s3, sc_s3, ss_s3;
	hsb_t               hsb_s3;
	logic signed [31:0] d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= h_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hc_s3  <= hsb_out.hflip ? -hx : hx;
			hs_s3  <= hsb_out.hflip ? -hy : hy;
			sc_s3  <= (sx < ANG_W'(1)) ? ANG_W'(1) : sx;
			ss_s3  <= sy;
			hsb_s3 <= hsb_out;
			d_s3   <= d_c;
		end
	end

	// ---------------------------------------------------------------- s4: displacement, tan setup
	logic signed [65:0]   dxp, dyp, dxr, dyr;
	ang_t                 abs_ss;
	logic                 vld_s4;
	logic signed [33:0]   dx_s4, dy_s4;
	logic [D1_NUM_W-1:0]  num_s4;
	logic [D1_DEN_W-1:0]  den_s4;
	logic                 rneg_s4;
	logic [31:0]          dmag_s4;
	logic signed [31:0]   px_s4, py_s4, nspd_s4;
	logic [15:0]          hd_s4;

	assign dxp    = d_s3 * hc_s3;
	assign dyp    = d_s3 * hs_s3;
	assign dxr    = dxp + 66'sd536870912;
	assign dyr    = dyp + 66'sd536870912;
	assign abs_ss = ss_s3[ANG_W-1] ? -ss_s3 : ss_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s4   <= dxr[63:30];
			dy_s4   <= dyr[63:30];
			num_s4  <= {abs_ss[31:0], 16'h0000};
			den_s4  <= sc_s3[31:0];
			rneg_s4 <= ss_s3[ANG_W-1] ^ d_s3[31];
			dmag_s4 <= d_s3[31] ? 32'(-d_s3) : 32'(d_s3);
			px_s4   <= hsb_s3.px;
			py_s4   <= hsb_s3.py;
			hd_s4   <= hsb_s3.hd;
			nspd_s4 <= hsb_s3.nspd;
		end
	end

	// ---------------------------------------------------------------- tangent divider
	d1sb_t               d1_in, d1_out;
	logic                d1_vld;
	logic [D1_NUM_W-1:0] tq_mag;

	assign d1_in.nx   = sat32(35'(px_s4) + 35'(dx_s4));
	assign d1_in.ny   = sat32(35'(py_s4) + 35'(dy_s4));
	assign d1_in.hd   = hd_s4;
	assign d1_in.nspd = nspd_s4;
	assign d1_in.dmag = dmag_s4;
	assign d1_in.rneg = rneg_s4;

	kbe_div #(
		.NUM_W (D1_NUM_W),
		.DEN_W (D1_DEN_W),
		.SB_W  ($bits(d1sb_t))
	) u_div_tan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (vld_s4),
		.num_i  (num_s4),
		.den_i  (den_s4),
		.sb_i   (d1_in),
		.vld_o  (d1_vld),
		.quo_o  (tq_mag),
		.sb_o   (d1_out)
	);

	// ---------------------------------------------------------------- s5: travel times tangent
	logic                vld_s5;
	logic [D2_NUM_W-1:0] prod_s5;
	d2sb_t               d2sb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s5      <= d1_out.dmag * tq_mag[TQ_W-1:0];
			d2sb_s5.nx   <= d1_out.nx;
			d2sb_s5.ny   <= d1_out.ny;
			d2sb_s5.hd   <= d1_out.hd;
			d2sb_s5.nspd <= d1_out.nspd;
			d2sb_s5.rneg <= d1_out.rneg;
		end
	end

	// ---------------------------------------------------------------- yaw rate divider
	d2sb_t               d2_out;
	logic                d2_vld;
	logic [D2_NUM_W-1:0] r_mag;

	kbe_div #(
		.NUM_W (D2_NUM_W),
		.DEN_W (D2_DEN_W),
		.SB_W  ($bits(d2sb_t))
	) u_div_rate (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (vld_s5),
		.num_i  (prod_s5),
		.den_i  (wb_eff),
		.sb_i   (d2sb_s5),
		.vld_o  (d2_vld),
		.quo_o  (r_mag),
		.sb_o   (d2_out)
	);

	// ---------------------------------------------------------------- s6: partial products
	// Only bits 55:40 of rate * RAD_TO_BAM matter, so work modulo 2^56.
	logic [R_W-1:0]   r_w;
	logic [57:0]      lo_p, hi_p;
	logic             vld_s6;
	logic [57:0]      lo_s6;
	logic [27:0]      hi_s6;
	logic signed [31:0] nx_s6, ny_s6, nspd_s6;
	logic [15:0]      hd_s6;

	assign r_w  = d2_out.rneg ? R_W'(-{{(R_W-D2_NUM_W){1'b0}}, r_mag})
	                          : {{(R_W-D2_NUM_W){1'b0}}, r_mag};
	assign lo_p = r_w[27:0] * RAD_TO_BAM;
	assign hi_p = r_w[55:28] * RAD_TO_BAM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s6   <= lo_p;
			hi_s6   <= hi_p[27:0];
			nx_s6   <= d2_out.nx;
			ny_s6   <= d2_out.ny;
			hd_s6   <= d2_out.hd;
			nspd_s6 <= d2_out.nspd;
		end
	end

	// ---------------------------------------------------------------- s7: output register
	logic [R_W-1:0] dh_sum;

	assign dh_sum = lo_s6[R_W-1:0] + {hi_s6, 28'h0000000} + 56'h00_0080_0000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			next_pos_x   <= nx_s6;
			next_pos_y   <= ny_s6;
			next_heading <= hd_s6 + dh_sum[55:40];
			next_speed   <= nspd_s6;
		end
	end

	// ---------------------------------------------------------------- checks
	`KBE_ASSERT_ALWAYS(a_cordic_lockstep, h_vld == s_vld, "CORDIC lanes out of step")
	`KBE_ASSERT_SAME(a_heading_fold, vld_s2, (ha_s2 <= QUARTER_TURN) && (ha_s2 >= -QUARTER_TURN), "heading fold out of range")
	`KBE_ASSERT_SAME(a_tan_fits, d1_vld, tq_mag[D1_NUM_W-1:TQ_W] == '0, "tangent quotient too wide")
	`KBE_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld_s4) && $stable(vld_s5), "pipe moved while stalled")

endmodule
